/* design/assert_macros.svh */
// assertion macros used by the interval_set_merge_insert design file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent at the next clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/isetm_pkg.sv */
// types and constants for the interval set merge insert block
// no dependencies
package isetm_pkg;

   localparam int ONE_DA = 65536;
   localparam int LIMIT_RESET = 196608000;
   localparam int LIMIT_WIDTH = 31;
   localparam int INDEX_WIDTH = 8;
   localparam int WIDE_WIDTH = 66;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SHIFT = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IGNORED = 3'd0,
      ST_INSERTED = 3'd1,
      ST_BRIDGED = 3'd2,
      ST_EXT_RIGHT = 3'd3,
      ST_EXT_LEFT = 3'd4,
      ST_FULL = 3'd5,
      ST_SHIFT_DONE = 3'd6,
      ST_READ = 3'd7
   } status_type;

   typedef enum logic [4:0] {
      S_BUILD,
      S_IDLE,
      S_ACHK,
      S_ARD,
      S_ACMP,
      S_ADEC,
      S_SRRD,
      S_SRWR,
      S_SLRD,
      S_SLWR,
      S_AEND,
      S_CPRD,
      S_CPWR,
      S_SHRD,
      S_SHADD,
      S_RSRD,
      S_RSWR,
      S_RD,
      S_RDW,
      S_OUT
   } state_type;

endpackage

/* design/isetm_ram.sv */
// generic single write port ram with registered read
// no dependencies
module isetm_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/interval_set_merge_insert.sv */
// top level of the interval set merge insert block: sequencer, compare datapath, two rams
// depends on isetm_pkg, isetm_ram and assert_macros.svh
//
// usage
//   req_* carries one transaction: operation, low/high mass, shift amount, entry index.
//   a transaction is taken when req_valid is high and req_stall is low; req_stall is high
//   whenever the sequencer is busy. rsp_* returns exactly one result per transaction.
//   csr_wr_en/csr_wr_data write the mass limit; write only while the block is idle (the block does not check).
// sequence
//   add: a search through the table, then entry moves when inserting or bridging
//   (table ram has one read and one write port).
//   shifted copy: a snapshot copy of the table, then one add per entry after the first,
//   and a restore from the snapshot if the table fills.
//   one transaction is worked on at a time.
// reset
//   synchronous reset rewrites the three sentinels, with req_stall high.
// stall
//   a result held by rsp_stall stays in the output register; the next transaction may be
//   taken meanwhile, and its result waits until the output register is free.
module interval_set_merge_insert
   import isetm_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   parameter int MASS_WIDTH = 36
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic signed [MASS_WIDTH-1:0]         req_low_mass,
   input  logic signed [MASS_WIDTH-1:0]         req_high_mass,
   input  logic signed [MASS_WIDTH-1:0]         req_shift_amount,
   input  logic [INDEX_WIDTH-1:0]               req_entry_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     rsp_entry_count,
   output logic signed [MASS_WIDTH-1:0]         rsp_read_start,
   output logic signed [MASS_WIDTH-1:0]         rsp_read_end,
   input  logic                                 csr_wr_en,
   input  logic [LIMIT_WIDTH-1:0]               csr_wr_data
);

`include "assert_macros.svh"

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int MW = MASS_WIDTH;
   localparam int EW = 2 * MASS_WIDTH;
   localparam int XW = WIDE_WIDTH;
   localparam logic signed [XW-1:0] MAX_X = (XW'(1) <<< (MW - 1)) - XW'(1);
   localparam logic signed [MW-1:0] MASS_MIN = {1'b1, {(MW-1){1'b0}}};
   localparam logic signed [MW-1:0] MASS_MAX = {1'b0, {(MW-1){1'b1}}};
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   op_type                 op_ff, op_in;
   logic signed [MW-1:0]   lo_ff, lo_in, hi_ff, hi_in, shift_ff, shift_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic [CW-1:0]          r_ff, r_in, k_ff, k_in, i_ff, i_in;
   logic [CW-1:0]          used_ff, used_in, snap_used_ff, snap_used_in;
   logic                   has_l_ff, has_l_in, has_r_ff, has_r_in;
   logic [EW-1:0]          l_ff, l_in, rr_ff, rr_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   status_type             res_status_ff, res_status_in;
   logic signed [MW-1:0]   res_rs_ff, res_rs_in, res_re_ff, res_re_in;
   logic                   in_shift_ff, in_shift_in, boot_ff, boot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;
   logic signed [MW-1:0]   rsp_rs_ff, rsp_rs_in, rsp_re_ff, rsp_re_in;

   logic          tbl_we, snap_we;
   logic [AW-1:0] tbl_wa, tbl_ra, snap_wa, snap_ra;
   logic [EW-1:0] tbl_wd, snap_wd, tbl_rd, snap_rd;

   logic signed [MW-1:0] rd_s, rd_e, l_s, l_e, r_s, r_e, sn_s, sn_e, sa_s, sa_e;
   logic signed [XW-1:0] hi_x, lim_x, lim10_x, c_s1, c_e1, c_s2, c_e2;
   logic signed [MW-1:0] sent_s [3];
   logic signed [MW-1:0] sent_e [3];
   logic [CW-1:0]        sent_cnt, r_m1, k_m1, k_p1;
   logic [31:0]          idx32;
   logic                 accept, bad, dup, do_ins, do_brg, do_exr, do_exl;
   logic                 out_free, idx_ok;

   function automatic logic signed [MW-1:0] sat_add(input logic signed [MW-1:0] a,
                                                    input logic signed [MW-1:0] b);
      logic signed [MW:0] s;
      s = {a[MW-1], a} + {b[MW-1], b};
      if (s[MW] != s[MW-1]) begin
         return s[MW] ? MASS_MIN : MASS_MAX;
      end
      return s[MW-1:0];
   endfunction

   function automatic logic signed [XW-1:0] clamp_hi(input logic signed [XW-1:0] v);
      return (v > MAX_X) ? MAX_X : v;
   endfunction

   isetm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wa),
      .wr_data (tbl_wd),
      .rd_addr (tbl_ra),
      .rd_data (tbl_rd)
   );

   isetm_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_snapshot (
      .clock   (clock),
      .wr_en   (snap_we),
      .wr_addr (snap_wa),
      .wr_data (snap_wd),
      .rd_addr (snap_ra),
      .rd_data (snap_rd)
   );

   // compare datapath and sentinel values
   always_comb begin
      rd_s = tbl_rd[EW-1:MW];
      rd_e = tbl_rd[MW-1:0];
      l_s = l_ff[EW-1:MW];
      l_e = l_ff[MW-1:0];
      r_s = rr_ff[EW-1:MW];
      r_e = rr_ff[MW-1:0];
      sn_s = snap_rd[EW-1:MW];
      sn_e = snap_rd[MW-1:0];
      sa_s = sat_add(sn_s, shift_ff);
      sa_e = sat_add(sn_e, shift_ff);
      hi_x = {{(XW-MW){hi_ff[MW-1]}}, hi_ff};
      lim_x = {{(XW-LIMIT_WIDTH){1'b0}}, limit_ff};
      lim10_x = (lim_x <<< 3) + (lim_x <<< 1);
      c_s1 = clamp_hi(lim_x);
      c_e1 = clamp_hi(lim_x + XW'(ONE_DA));
      c_s2 = clamp_hi(lim10_x);
      c_e2 = clamp_hi(lim10_x <<< 1);
      sent_s[0] = MASS_MIN;
      sent_e[0] = MASS_MIN;
      sent_s[1] = c_s1[MW-1:0];
      sent_e[1] = c_e1[MW-1:0];
      sent_s[2] = c_s2[MW-1:0];
      sent_e[2] = c_e2[MW-1:0];
      sent_cnt = (c_s2 == c_s1) ? CW'(2) : CW'(3);
      r_m1 = r_ff - CW'(1);
      k_m1 = k_ff - CW'(1);
      k_p1 = k_ff + CW'(1);
      idx32 = {{(32-INDEX_WIDTH){1'b0}}, idx_ff};
      idx_ok = idx32 < 32'(used_ff);
      bad = (lo_ff >= hi_ff) || (hi_x > lim_x);
      dup = has_r_ff && (r_s == lo_ff);
      do_ins = (!has_r_ff || (r_s > hi_ff)) && (!has_l_ff || (l_e < lo_ff));
      do_brg = has_l_ff && has_r_ff && (l_e > lo_ff) && (r_s < hi_ff);
      do_exr = has_l_ff && (l_s < lo_ff) && (l_e >= lo_ff) && (l_e < hi_ff);
      do_exl = has_r_ff && (r_s > lo_ff) && (r_s <= hi_ff);
      accept = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_BUILD: begin
            if (k_ff == CW'(2)) begin
               state_in = boot_ff ? S_IDLE : S_OUT;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_operation))
                  OP_ADD:   state_in = S_ACHK;
                  OP_SHIFT: state_in = S_CPRD;
                  OP_CLEAR: state_in = S_BUILD;
                  OP_READ:  state_in = S_RD;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_ACHK:  state_in = bad ? S_AEND : S_ARD;
         S_ARD:   state_in = (r_ff >= used_ff) ? S_ADEC : S_ACMP;
         S_ACMP:  state_in = (rd_s < lo_ff) ? S_ARD : S_ADEC;
         S_ADEC: begin
            if (dup) begin
               state_in = S_AEND;
            end else if (do_ins) begin
               state_in = (used_ff >= DEPTH_C) ? S_AEND : S_SRRD;
            end else if (do_brg) begin
               state_in = S_SLRD;
            end else begin
               state_in = S_AEND;
            end
         end
         S_SRRD:  state_in = (k_ff == r_ff) ? S_AEND : S_SRWR;
         S_SRWR:  state_in = S_SRRD;
         S_SLRD:  state_in = (k_p1 >= used_ff) ? S_AEND : S_SLWR;
         S_SLWR:  state_in = S_SLRD;
         S_AEND: begin
            if (!in_shift_ff) begin
               state_in = S_OUT;
            end else if (res_status_ff == ST_FULL) begin
               state_in = S_RSRD;
            end else begin
               state_in = S_SHRD;
            end
         end
         S_CPRD:  state_in = (k_ff >= used_ff) ? S_SHRD : S_CPWR;
         S_CPWR:  state_in = S_CPRD;
         S_SHRD:  state_in = (i_ff >= snap_used_ff) ? S_OUT : S_SHADD;
         S_SHADD: state_in = S_ACHK;
         S_RSRD:  state_in = (k_ff >= snap_used_ff) ? S_OUT : S_RSWR;
         S_RSWR:  state_in = S_RSRD;
         S_RD:    state_in = idx_ok ? S_RDW : S_OUT;
         S_RDW:   state_in = S_OUT;
         S_OUT:   state_in = out_free ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in = op_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      shift_in = shift_ff;
      idx_in = idx_ff;
      r_in = r_ff;
      k_in = k_ff;
      i_in = i_ff;
      used_in = used_ff;
      snap_used_in = snap_used_ff;
      has_l_in = has_l_ff;
      has_r_in = has_r_ff;
      l_in = l_ff;
      rr_in = rr_ff;
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
      res_status_in = res_status_ff;
      res_rs_in = res_rs_ff;
      res_re_in = res_re_ff;
      in_shift_in = in_shift_ff;
      boot_in = boot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in = rsp_count_ff;
      rsp_rs_in = rsp_rs_ff;
      rsp_re_in = rsp_re_ff;
      tbl_we = 1'b0;
      tbl_wa = r_ff[AW-1:0];
      tbl_wd = {lo_ff, hi_ff};
      tbl_ra = r_ff[AW-1:0];
      snap_we = 1'b0;
      snap_wa = k_ff[AW-1:0];
      snap_wd = tbl_rd;
      snap_ra = k_ff[AW-1:0];
      unique case (state_ff)
         S_BUILD: begin
            tbl_we = 1'b1;
            tbl_wa = k_ff[AW-1:0];
            tbl_wd = {sent_s[k_ff[1:0]], sent_e[k_ff[1:0]]};
            k_in = k_p1;
            if (k_ff == CW'(2)) begin
               used_in = sent_cnt;
               boot_in = 1'b0;
               res_status_in = ST_IGNORED;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in = op_type'(req_operation);
               lo_in = req_low_mass;
               hi_in = req_high_mass;
               shift_in = req_shift_amount;
               idx_in = req_entry_index;
               in_shift_in = 1'b0;
               k_in = '0;
               res_rs_in = '0;
               res_re_in = '0;
            end
         end
         S_ACHK: begin
            res_status_in = ST_IGNORED;
            r_in = '0;
            has_l_in = 1'b0;
         end
         S_ARD: begin
            has_r_in = 1'b0;
         end
         S_ACMP: begin
            if (rd_s < lo_ff) begin
               l_in = tbl_rd;
               has_l_in = 1'b1;
               r_in = r_ff + CW'(1);
            end else begin
               rr_in = tbl_rd;
               has_r_in = 1'b1;
            end
         end
         S_ADEC: begin
            k_in = do_ins ? used_ff : r_ff;
            if (dup) begin
               res_status_in = ST_IGNORED;
            end else if (do_ins) begin
               res_status_in = (used_ff >= DEPTH_C) ? ST_FULL : ST_INSERTED;
            end else if (do_brg) begin
               tbl_we = 1'b1;
               tbl_wa = r_m1[AW-1:0];
               tbl_wd = {l_s, r_e};
            end else if (do_exr) begin
               tbl_we = 1'b1;
               tbl_wa = r_m1[AW-1:0];
               tbl_wd = {l_s, hi_ff};
               res_status_in = ST_EXT_RIGHT;
            end else if (do_exl) begin
               tbl_we = 1'b1;
               tbl_wd = {lo_ff, r_e};
               res_status_in = ST_EXT_LEFT;
            end
         end
         S_SRRD: begin
            tbl_ra = k_m1[AW-1:0];
            if (k_ff == r_ff) begin
               tbl_we = 1'b1;
               used_in = used_ff + CW'(1);
               res_status_in = ST_INSERTED;
            end
         end
         S_SRWR: begin
            tbl_we = 1'b1;
            tbl_wa = k_ff[AW-1:0];
            tbl_wd = tbl_rd;
            k_in = k_m1;
         end
         S_SLRD: begin
            tbl_ra = k_p1[AW-1:0];
            if (k_p1 >= used_ff) begin
               used_in = used_ff - CW'(1);
               res_status_in = ST_BRIDGED;
            end
         end
         S_SLWR: begin
            tbl_we = 1'b1;
            tbl_wa = k_ff[AW-1:0];
            tbl_wd = tbl_rd;
            k_in = k_p1;
         end
         S_AEND: begin
            k_in = '0;
            i_in = i_ff + CW'(1);
         end
         S_CPRD: begin
            tbl_ra = k_ff[AW-1:0];
            if (k_ff >= used_ff) begin
               snap_used_in = used_ff;
               i_in = CW'(1);
               res_status_in = ST_SHIFT_DONE;
            end
         end
         S_CPWR: begin
            snap_we = 1'b1;
            k_in = k_p1;
         end
         S_SHRD: begin
            snap_ra = i_ff[AW-1:0];
            if (i_ff >= snap_used_ff) begin
               res_status_in = ST_SHIFT_DONE;
            end
         end
         S_SHADD: begin
            lo_in = sa_s;
            hi_in = sa_e;
            in_shift_in = 1'b1;
         end
         S_RSRD: begin
            snap_ra = k_ff[AW-1:0];
            if (k_ff >= snap_used_ff) begin
               used_in = snap_used_ff;
               res_status_in = ST_FULL;
            end
         end
         S_RSWR: begin
            tbl_we = 1'b1;
            tbl_wa = k_ff[AW-1:0];
            tbl_wd = snap_rd;
            k_in = k_p1;
         end
         S_RD: begin
            tbl_ra = idx32[AW-1:0];
            res_status_in = ST_IGNORED;
         end
         S_RDW: begin
            res_status_in = ST_READ;
            res_rs_in = rd_s;
            res_re_in = rd_e;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in = used_ff;
               rsp_rs_in = res_rs_ff;
               rsp_re_in = res_re_ff;
            end
         end
         default: begin
            tbl_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BUILD;
         k_ff <= '0;
         boot_ff <= 1'b1;
         used_ff <= '0;
         limit_ff <= LIMIT_WIDTH'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
         in_shift_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         boot_ff <= boot_in;
         used_ff <= used_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         in_shift_ff <= in_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      shift_ff <= shift_in;
      idx_ff <= idx_in;
      r_ff <= r_in;
      i_ff <= i_in;
      snap_used_ff <= snap_used_in;
      has_l_ff <= has_l_in;
      has_r_ff <= has_r_in;
      l_ff <= l_in;
      rr_ff <= rr_in;
      res_status_ff <= res_status_in;
      res_rs_ff <= res_rs_in;
      res_re_ff <= res_re_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff <= rsp_count_in;
      rsp_rs_ff <= rsp_rs_in;
      rsp_re_ff <= rsp_re_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_start = rsp_rs_ff;
   assign rsp_read_end = rsp_re_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, used_ff <= DEPTH_C, "entry count above depth")
   `ASSERT_ALWAYS(a_sentinels_kept, clock, reset,
                  (state_ff != S_IDLE) || (used_ff >= CW'(2)), "sentinels missing when idle")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, state_ff != S_IDLE,
                "sequencer idle after a transaction was taken")

endmodule

/* tb/interval_set_merge_insert_tb.sv */
// testbench for interval_set_merge_insert: directed and random transactions with idling,
// checked against a scoreboard that predicts the sorted interval table
// depends on isetm_pkg and the interval_set_merge_insert design
`timescale 1ns / 1ps

module interval_set_merge_insert_tb;
   import isetm_pkg::*;

   localparam int DEPTH = 256;
   localparam longint MASS_MAX = 64'sd34359738367;
   localparam longint MASS_MIN = -64'sd34359738368;
   localparam longint LIMIT_MAX = 1717986918;
   localparam int WATCHDOG_LIMIT = 3000000;

   typedef struct {
      status_type status;
      int count;
      longint rd_start;
      longint rd_end;
   } interval_result_type;

   class interval_scoreboard_type;
      longint starts[DEPTH];
      longint ends[DEPTH];
      longint snap_starts[DEPTH];
      longint snap_ends[DEPTH];
      int used;
      longint limit;
      interval_result_type pending[$];
      int errors;

      function new();
         limit = LIMIT_RESET;
         errors = 0;
         rebuild();
      endfunction

      function longint clamp(longint x);
         if (x > MASS_MAX) return MASS_MAX;
         if (x < MASS_MIN) return MASS_MIN;
         return x;
      endfunction

      function longint sat_sum(longint a, longint b);
         return clamp(a + b);
      endfunction

      function void append_if_new(longint lo, longint hi);
         if (used >= DEPTH) return;
         if (used > 0 && starts[used-1] >= lo) return;
         starts[used] = lo;
         ends[used] = hi;
         used++;
      endfunction

      function void rebuild();
         used = 0;
         append_if_new(MASS_MIN, MASS_MIN);
         append_if_new(clamp(limit), clamp(limit + ONE_DA));
         append_if_new(clamp(limit * 10), clamp(limit * 20));
      endfunction

      function status_type add_interval(longint lo, longint hi);
         int r, l;
         bit has_r, has_l;
         r = 0;
         if (lo >= hi || hi > limit) return ST_IGNORED;
         while (r < used && starts[r] < lo) r++;
         has_r = r < used;
         if (has_r && starts[r] == lo) return ST_IGNORED;
         has_l = r > 0;
         l = has_l ? r - 1 : 0;
         if ((!has_r || starts[r] > hi) && (!has_l || ends[l] < lo)) begin
            if (used >= DEPTH) return ST_FULL;
            for (int k = used; k > r; k--) begin
               starts[k] = starts[k-1];
               ends[k] = ends[k-1];
            end
            starts[r] = lo;
            ends[r] = hi;
            used++;
            return ST_INSERTED;
         end
         if (has_l && has_r && ends[l] > lo && starts[r] < hi) begin
            ends[l] = ends[r];
            for (int k = r; k + 1 < used; k++) begin
               starts[k] = starts[k+1];
               ends[k] = ends[k+1];
            end
            used--;
            return ST_BRIDGED;
         end
         if (has_l && starts[l] < lo && ends[l] >= lo && ends[l] < hi) begin
            ends[l] = hi;
            return ST_EXT_RIGHT;
         end
         if (has_r && starts[r] > lo && starts[r] <= hi) begin
            starts[r] = lo;
            return ST_EXT_LEFT;
         end
         return ST_IGNORED;
      endfunction

      function status_type add_shifted(longint shift);
         int snap_used;
         snap_starts = starts;
         snap_ends = ends;
         snap_used = used;
         for (int i = 1; i < snap_used; i++) begin
            if (add_interval(sat_sum(snap_starts[i], shift),
                             sat_sum(snap_ends[i], shift)) == ST_FULL) begin
               starts = snap_starts;
               ends = snap_ends;
               used = snap_used;
               return ST_FULL;
            end
         end
         return ST_SHIFT_DONE;
      endfunction

      function void note_input(op_type op, longint lo, longint hi, longint sh, int idx);
         interval_result_type res;
         res.rd_start = 0;
         res.rd_end = 0;
         res.status = ST_IGNORED;
         case (op)
            OP_ADD: res.status = add_interval(lo, hi);
            OP_SHIFT: res.status = add_shifted(sh);
            OP_CLEAR: rebuild();
            default: begin
               if (idx < used) begin
                  res.rd_start = starts[idx];
                  res.rd_end = ends[idx];
                  res.status = ST_READ;
               end
            end
         endcase
         res.count = used;
         pending.push_back(res);
      endfunction

      function void check_result(logic [2:0] st, int cnt, longint rs, longint re);
         interval_result_type exp_res;
         if (pending.size() == 0) begin
            $error("unexpected result transaction, status %0d", st);
            errors++;
            return;
         end
         exp_res = pending.pop_front();
         if (st !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, st);
            errors++;
         end
         if (cnt != exp_res.count) begin
            $error("entry_count: expected %0d, actual %0d", exp_res.count, cnt);
            errors++;
         end
         if (rs != exp_res.rd_start) begin
            $error("read_start: expected %0d, actual %0d", exp_res.rd_start, rs);
            errors++;
         end
         if (re != exp_res.rd_end) begin
            $error("read_end: expected %0d, actual %0d", exp_res.rd_end, re);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_operation;
   logic signed [35:0] req_low_mass;
   logic signed [35:0] req_high_mass;
   logic signed [35:0] req_shift_amount;
   logic [INDEX_WIDTH-1:0] req_entry_index;
   logic rsp_valid;
   logic rsp_stall;
   logic [2:0] rsp_status;
   logic [8:0] rsp_entry_count;
   logic signed [35:0] rsp_read_start;
   logic signed [35:0] rsp_read_end;
   logic csr_wr_en;
   logic [LIMIT_WIDTH-1:0] csr_wr_data;

   interval_scoreboard_type table_sb;
   int idle_mode;
   int hold_left;
   int quiet_cycles;

   interval_set_merge_insert #(.TABLE_DEPTH(256), .MASS_WIDTH(36)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_low_mass(req_low_mass),
      .req_high_mass(req_high_mass),
      .req_shift_amount(req_shift_amount),
      .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_read_start(rsp_read_start),
      .rsp_read_end(rsp_read_end),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   function longint rnd36();
      logic signed [35:0] v;
      v = {4'($urandom_range(15)), 32'($urandom)};
      return longint'(v);
   endfunction

   // receiver side
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= (idle_mode == 2) ? chance(85) : (idle_mode == 3) ? chance(6) : 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         table_sb.check_result(rsp_status, int'(rsp_entry_count),
                               longint'(rsp_read_start), longint'(rsp_read_end));
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("interval_set_merge_insert_tb: done, errors");
         $finish;
      end
   end

   task automatic drive(op_type op, longint lo, longint hi, longint sh, int idx);
      bit idle_now;
      idle_now = (idle_mode == 1) ? chance(85) : (idle_mode == 3) ? chance(6) : 1'b0;
      while (idle_now) begin
         req_valid <= 1'b0;
         @(posedge clock);
         idle_now = (idle_mode == 1) ? chance(85) : (idle_mode == 3) ? chance(6) : 1'b0;
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_low_mass <= 36'(lo);
      req_high_mass <= 36'(hi);
      req_shift_amount <= 36'(sh);
      req_entry_index <= INDEX_WIDTH'(idx);
      do @(posedge clock); while (req_stall);
      table_sb.note_input(op, lo, hi, sh, idx);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (table_sb.pending.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_limit(longint value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= LIMIT_WIDTH'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      table_sb.limit = value;
   endtask

   task automatic random_item();
      int pick;
      longint win, lo, hi, sh;
      pick = $urandom_range(99);
      win = (table_sb.limit < 2000000) ? table_sb.limit : 2000000;
      lo = $urandom_range(32'(win));
      hi = lo + $urandom_range(200000);
      sh = chance(50) ? longint'($urandom_range(400000)) - 200000 : rnd36();
      if (pick < 62)
         drive(OP_ADD, lo, hi, rnd36(), $urandom_range(255));
      else if (pick < 72)
         drive(OP_ADD, rnd36(), rnd36(), rnd36(), $urandom_range(255));
      else if (pick < 78)
         drive(OP_SHIFT, rnd36(), rnd36(), sh, $urandom_range(255));
      else if (pick < 95)
         drive(OP_READ, rnd36(), rnd36(), rnd36(),
               chance(70) ? $urandom_range(table_sb.used) : $urandom_range(255));
      else
         drive(OP_CLEAR, rnd36(), rnd36(), rnd36(), $urandom_range(255));
   endtask

   initial begin
      table_sb = new();
      idle_mode = 0;
      hold_left = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ADD;
      req_low_mass = '0;
      req_high_mass = '0;
      req_shift_amount = '0;
      req_entry_index = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      drive(OP_READ, 0, 0, 0, 0);
      drive(OP_READ, 0, 0, 0, 2);
      drive(OP_READ, 0, 0, 0, 3);
      drive(OP_READ, 0, 0, 0, 255);
      drive(OP_ADD, 1000, 1000, 0, 0);
      drive(OP_ADD, 2000, 1000, 0, 0);
      drive(OP_ADD, 1000, LIMIT_RESET + 1, 0, 0);
      drive(OP_ADD, 1000, 5000, 0, 0);
      drive(OP_ADD, 1000, 9000, 0, 0);
      drive(OP_ADD, 3000, 7000, 0, 0);
      drive(OP_ADD, 20000, 30000, 0, 0);
      drive(OP_ADD, 15000, 20000, 0, 0);
      drive(OP_ADD, 6000, 16000, 0, 0);
      drive(OP_ADD, 2000, 3000, 0, 0);
      drive(OP_ADD, MASS_MIN, 0, 0, 0);
      drive(OP_ADD, MASS_MIN + 1, 500, 0, 0);
      drive(OP_ADD, LIMIT_RESET - 100, LIMIT_RESET, 0, 0);
      drive(OP_SHIFT, 0, 0, 40000, 0);
      drive(OP_SHIFT, 0, 0, MASS_MAX, 0);
      drive(OP_SHIFT, 0, 0, MASS_MIN, 0);
      drive(OP_READ, 0, 0, 0, 1);
      drive(OP_CLEAR, MASS_MAX, MASS_MIN, MASS_MAX, 255);
      write_limit(0);
      drive(OP_CLEAR, 0, 0, 0, 0);
      drive(OP_ADD, -5, 0, 0, 0);
      drive(OP_READ, 0, 0, 0, 1);
      write_limit(LIMIT_MAX);
      drive(OP_CLEAR, 0, 0, 0, 0);
      drive(OP_READ, 0, 0, 0, 2);

      // fill the table to capacity
      write_limit(LIMIT_RESET);
      drive(OP_CLEAR, 0, 0, 0, 0);
      for (int k = 0; k < 260; k++)
         drive(OP_ADD, k * 500000 + 1, k * 500000 + 101, rnd36(), $urandom_range(255));
      drive(OP_SHIFT, 0, 0, 1, 0);
      drive(OP_SHIFT, 0, 0, 250000, 0);
      for (int k = 0; k < 6; k++)
         drive(OP_READ, 0, 0, 0, $urandom_range(255));
      drive(OP_CLEAR, 0, 0, 0, 0);

      for (int m = 0; m < 4; m++) begin
         drain();
         idle_mode = m;
         case (m)
            0: write_limit(LIMIT_MAX);
            1: write_limit($urandom_range(32'(LIMIT_MAX)));
            2: write_limit($urandom_range(3000000));
            default: write_limit(LIMIT_RESET);
         endcase
         if (chance(75)) drive(OP_CLEAR, 0, 0, 0, 0);
         if (m == 0) begin
            hold_left = 400;
            for (int k = 0; k < 12; k++) random_item();
         end
         for (int k = 0; k < 215; k++) begin
            if (k % 35 == 34) drive(OP_CLEAR, rnd36(), rnd36(), rnd36(), $urandom_range(255));
            random_item();
         end
      end

      drain();
      idle_mode = 0;
      repeat (50) @(posedge clock);
      if (table_sb.errors == 0 && table_sb.pending.size() == 0)
         $display("interval_set_merge_insert_tb: done, clean");
      else
         $display("interval_set_merge_insert_tb: done, errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+design
design/isetm_pkg.sv
design/isetm_ram.sv
design/interval_set_merge_insert.sv
tb/interval_set_merge_insert_tb.sv
